### sv/interval_booking_overlap_table_macros.svh
// Assertion macros for the interval booking table checker
`ifndef INTERVAL_BOOKING_OVERLAP_TABLE_MACROS_SVH
`define INTERVAL_BOOKING_OVERLAP_TABLE_MACROS_SVH

// same-cycle implication
`define IBOT_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IBOT_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ibot_pkg.sv
// Shared types and codes for the interval booking table
`timescale 1ns / 1ps

package ibot_pkg;

  localparam int unsigned TIME_W = 32;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_BOOKED  = 2'd0;
  localparam status_t STATUS_OVERLAP = 2'd1;
  localparam status_t STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic ovl;
    logic dup;
  } cmp_t;

endpackage

### sv/ibot_cmp.sv
// Shared overlap and duplicate compare unit
`timescale 1ns / 1ps

module ibot_cmp (
  input  logic [ibot_pkg::TIME_W-1:0] rs,
  input  logic [ibot_pkg::TIME_W-1:0] re,
  input  logic [ibot_pkg::TIME_W-1:0] s,
  input  logic [ibot_pkg::TIME_W-1:0] e,
  output ibot_pkg::cmp_t              res
);

  logic lt_s;

  assign lt_s    = rs < s;
  assign res.ovl = (lt_s && (re > s)) || (!lt_s && (rs < e));
  assign res.dup = (s == rs) && (e == re);

endmodule

### sv/ibot_store.sv
// Interval storage memory, one write and one registered read port
`timescale 1ns / 1ps

module ibot_store #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned AW      = 6
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [ibot_pkg::TIME_W-1:0]   wr_start,
  input  logic [ibot_pkg::TIME_W-1:0]   wr_end,
  input  logic [AW-1:0]                 rd_addr,
  output logic [ibot_pkg::TIME_W-1:0]   rd_start,
  output logic [ibot_pkg::TIME_W-1:0]   rd_end
);

  logic [2*ibot_pkg::TIME_W-1:0] mem [ENTRIES];
  logic [2*ibot_pkg::TIME_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_start, wr_end};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  assign rd_start = rd_data[2*ibot_pkg::TIME_W-1:ibot_pkg::TIME_W];
  assign rd_end   = rd_data[ibot_pkg::TIME_W-1:0];

endmodule

### sv/interval_booking_overlap_table.sv
// Top level of the interval booking table with overlap check
//
//   channel   direction  handshake            payload
//   request   in         start / busy         req_start, req_end
//   result    out        done (one cycle)     accepted, status
//
// With stored intervals, an accepted request passes through the scan, drain and
// result states before done is strobed; with an empty table it goes straight
// to the result state. The scan reads the storage memory one entry per cycle.
// busy is high from the accept until the result is strobed; a new request
// may be accepted in the cycle that done is high.
// rst clears the fill count and the sequencer; stored intervals need no clear.
// Results cannot be held off by the receiver.
`timescale 1ns / 1ps

module interval_booking_overlap_table #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [ibot_pkg::TIME_W-1:0] req_start,
  input  logic [ibot_pkg::TIME_W-1:0] req_end,
  output logic                        done,
  output logic                        accepted,
  output ibot_pkg::status_t           status
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t                      state, state_next;
  logic [CW-1:0]               used_count, used_count_next;
  logic [AW-1:0]               rd_idx, rd_idx_next;
  logic                        cmp_vld, cmp_vld_next;
  logic                        ovl_any, ovl_any_next;
  logic                        dup_any, dup_any_next;
  logic [ibot_pkg::TIME_W-1:0] rs, re;
  logic                        done_next, accepted_next;
  ibot_pkg::status_t           status_next;

  logic                        req_acc;
  logic [CW-1:0]               cnt_m1;
  logic                        rd_last;
  logic                        full;
  logic                        wr_en;
  logic [ibot_pkg::TIME_W-1:0] rd_start, rd_end;
  ibot_pkg::cmp_t              cmp_res;

  assign busy    = (state != S_IDLE);
  assign req_acc = start && !busy;
  assign cnt_m1  = used_count - CW'(1);
  assign rd_last = (rd_idx == cnt_m1[AW-1:0]);
  assign full    = (used_count == CW'(ENTRIES));
  assign wr_en   = (state == S_RESULT) && !ovl_any && !dup_any && !full;

  ibot_store #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (used_count[AW-1:0]),
    .wr_start (rs),
    .wr_end   (re),
    .rd_addr  (rd_idx),
    .rd_start (rd_start),
    .rd_end   (rd_end)
  );

  ibot_cmp u_cmp (
    .rs  (rs),
    .re  (re),
    .s   (rd_start),
    .e   (rd_end),
    .res (cmp_res)
  );

  always_comb begin
    state_next      = state;
    used_count_next = used_count;
    rd_idx_next     = rd_idx;
    cmp_vld_next    = 1'b0;
    ovl_any_next    = ovl_any;
    dup_any_next    = dup_any;
    done_next       = 1'b0;
    accepted_next   = accepted;
    status_next     = status;

    if (cmp_vld) begin
      ovl_any_next = ovl_any || cmp_res.ovl;
      dup_any_next = dup_any || cmp_res.dup;
    end

    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          rd_idx_next  = '0;
          ovl_any_next = 1'b0;
          dup_any_next = 1'b0;
          state_next   = (used_count == '0) ? S_RESULT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmp_vld_next = 1'b1;
        if (rd_last) begin
          state_next = S_DRAIN;
        end else begin
          rd_idx_next = rd_idx + AW'(1);
        end
      end
      S_DRAIN: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        priority if (ovl_any) begin
          accepted_next = 1'b0;
          status_next   = ibot_pkg::STATUS_OVERLAP;
        end else if (dup_any) begin
          accepted_next = 1'b1;
          status_next   = ibot_pkg::STATUS_BOOKED;
        end else if (full) begin
          accepted_next = 1'b0;
          status_next   = ibot_pkg::STATUS_FULL;
        end else begin
          accepted_next   = 1'b1;
          status_next     = ibot_pkg::STATUS_BOOKED;
          used_count_next = used_count + CW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      cmp_vld    <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      used_count <= used_count_next;
      cmp_vld    <= cmp_vld_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx   <= rd_idx_next;
    ovl_any  <= ovl_any_next;
    dup_any  <= dup_any_next;
    accepted <= accepted_next;
    status   <= status_next;
    if (req_acc) begin
      rs <= req_start;
      re <= req_end;
    end
  end

endmodule

### sv/ibot_chk.sv
// Port-level checker for the interval booking table, bound to the top level
`timescale 1ns / 1ps
`include "interval_booking_overlap_table_macros.svh"

module ibot_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              accepted,
  input ibot_pkg::status_t status
);

  `IBOT_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "request accepted but not busy")
  `IBOT_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result strobed while busy")
  `IBOT_ASSERT_NXT(a_done_single, clk, rst, done, !done, "result strobed twice in a row")
  `IBOT_ASSERT_IMP(a_accept_code, clk, rst, done, accepted == (status == ibot_pkg::STATUS_BOOKED), "accepted flag disagrees with status")
  `IBOT_ASSERT_IMP(a_status_legal, clk, rst, done, status == ibot_pkg::STATUS_BOOKED || status == ibot_pkg::STATUS_OVERLAP || status == ibot_pkg::STATUS_FULL, "unknown status code")

endmodule

bind interval_booking_overlap_table ibot_chk u_ibot_chk (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .accepted (accepted),
  .status   (status)
);
